// ----- design/text_console_cell_engine_macros.svh -----
// ---------------------------------------------------------------------------
// Text console cell engine assertion macros
// Concurrent assertion shorthands with and without a reset guard.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CELL_ENGINE_MACROS_SVH

// check prop on every edge outside reset
`define TCCE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop on every edge, reset included
`define TCCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tcce_pkg.sv -----
// ---------------------------------------------------------------------------
// Text console cell engine package
// Stream layouts, character codes, register indexes and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;

    localparam int IN_CODE_LSB  = 0;
    localparam int IN_COLOR_LSB = 8;
    localparam int IN_RCOL_LSB  = 32;
    localparam int IN_RROW_LSB  = 39;

    localparam int OUT_COL_LSB   = 0;
    localparam int OUT_ROW_LSB   = 7;
    localparam int OUT_CHAR_LSB  = 13;
    localparam int OUT_COLOR_LSB = 21;
    localparam int OUT_CCOL_LSB  = 45;
    localparam int OUT_CROW_LSB  = 52;
    localparam int OUT_PAD_W     = 6;

    localparam int OUT_GLYPH_BIT  = 0;
    localparam int OUT_SCROLL_BIT = 1;

    localparam logic [7:0]  NL_CODE    = 8'd10;
    localparam logic [7:0]  SPACE_CODE = 8'd32;
    localparam logic [7:0]  NUL_CODE   = 8'd0;
    localparam logic [23:0] BLACK      = 24'h000000;
    localparam logic [31:0] BLANK_CELL = {SPACE_CODE, BLACK};

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 4'd1;

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET    = 7'd25;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESULT,
        ST_COPY,
        ST_BLANK
    } t_state;

    typedef struct packed {
        logic [6:0]  cell_col;
        logic [5:0]  cell_row;
        logic [7:0]  cell_char;
        logic [23:0] cell_color;
        logic        glyph_drawn;
        logic        scrolled;
        logic [6:0]  cursor_col;
        logic [5:0]  cursor_row;
    } t_result;

endpackage

`default_nettype wire

// ----- design/text_console_cell_engine.sv -----
// ---------------------------------------------------------------------------
// Text console cell engine
// Printable character: one transaction per cycle while the result register is free and
// no scroll follows; other prints, stalled results and cell reads wait in the result
// state for the registered RAM read and a free result register. A scroll adds row copies,
// bottom-row clear and last write-back. Reset: a pass over MAX_ROWS*2**clog2(MAX_COLS)
// words (8192 by default) blanks the RAM, with input held off and configuration taken.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_cell_engine
    import tcce_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // char_code, char_color, read_col, read_row, zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // cell_col, cell_row, cell_char, cell_color, cursor_col, cursor_row, zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // glyph_drawn, scrolled
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser
);

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NCW   = CW + 1;
    localparam int NRW   = RW + 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_ROWS * (2 ** CW);

    t_state          r_state, n_state;
    logic [7:0]      r_columns;
    logic [6:0]      r_rows;
    logic [CW-1:0]   r_cx, n_cx, r_sx, n_sx;
    logic [RW-1:0]   r_cy, n_cy, r_sy, n_sy;
    logic [AW-1:0]   r_caddr, n_caddr, r_waddr, n_waddr;
    logic [NCW-1:0]  r_snc, n_snc;
    logic [NRW-1:0]  r_snr, n_snr;
    logic            r_wv, n_wv, r_wblank, n_wblank;
    t_result         r_res, n_res;
    logic            r_res_rd, n_res_rd, r_res_blank, n_res_blank;
    logic            r_ovalid;
    t_result         r_out, out_data;
    logic            out_load, out_free;

    logic [31:0]     r_cells [DEPTH];
    logic [31:0]     r_q;
    logic            we, rd_en;
    logic [AW-1:0]   wa, rd_addr;
    logic [31:0]     wd;

    logic [NCW-1:0]  nc;
    logic [NRW-1:0]  nr;
    logic [8:0]      cols_ext;
    logic [7:0]      rows_ext;

    logic            in_req;
    logic [7:0]      in_code;
    logic [23:0]     in_color;
    logic [6:0]      in_rcol;
    logic [5:0]      in_rrow;
    logic            accept;
    logic            is_glyph, is_space, is_nl, adv, wrap, scroll, in_rng;
    logic [CW-1:0]   cx, nx;
    logic [RW-1:0]   cy, ny;
    logic [NCW-1:0]  x1;
    logic [NRW-1:0]  y1;
    t_result         pr_res, rd_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_RESET;
            r_rows    <= ROWS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COLUMNS: r_columns <= i_cfg_data;
                REG_ROWS:    r_rows    <= i_cfg_data[6:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        cols_ext = {1'b0, r_columns};
        rows_ext = {1'b0, r_rows};
        if (r_columns == 8'd0) begin
            nc = NCW'(1);
        end else if (cols_ext > 9'(MAX_COLS)) begin
            nc = NCW'(MAX_COLS);
        end else begin
            nc = NCW'(cols_ext);
        end
        if (r_rows == 7'd0) begin
            nr = NRW'(1);
        end else if (rows_ext > 8'(MAX_ROWS)) begin
            nr = NRW'(MAX_ROWS);
        end else begin
            nr = NRW'(rows_ext);
        end
    end

    assign in_req   = s_axis_tuser;
    assign in_code  = s_axis_tdata[IN_CODE_LSB +: 8];
    assign in_color = s_axis_tdata[IN_COLOR_LSB +: 24];
    assign in_rcol  = s_axis_tdata[IN_RCOL_LSB +: 7];
    assign in_rrow  = s_axis_tdata[IN_RROW_LSB +: 6];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    always_comb begin
        cx = (NCW'(r_cx) >= nc) ? CW'(nc - NCW'(1)) : r_cx;
        cy = (NRW'(r_cy) >= nr) ? RW'(nr - NRW'(1)) : r_cy;
        is_nl    = (in_code == NL_CODE);
        is_space = (in_code == SPACE_CODE);
        is_glyph = (in_code != NUL_CODE) && !is_nl && !is_space;
        adv      = is_glyph || is_space;
        x1       = NCW'(cx) + NCW'(1);
        y1       = NRW'(cy) + NRW'(1);
        wrap     = is_nl || (adv && (x1 >= nc));
        scroll   = wrap && (y1 >= nr);
        if (wrap) begin
            nx = '0;
        end else if (adv) begin
            nx = CW'(x1);
        end else begin
            nx = cx;
        end
        if (scroll) begin
            ny = RW'(nr - NRW'(1));
        end else if (wrap) begin
            ny = RW'(y1);
        end else begin
            ny = cy;
        end
        in_rng = (9'(in_rcol) < 9'(nc)) && (8'(in_rrow) < 8'(nr));

        pr_res.cell_col    = 7'(cx);
        pr_res.cell_row    = 6'(cy);
        pr_res.cell_char   = in_code;
        pr_res.cell_color  = in_color;
        pr_res.glyph_drawn = is_glyph;
        pr_res.scrolled    = scroll;
        pr_res.cursor_col  = 7'(nx);
        pr_res.cursor_row  = 6'(ny);

        rd_res.cell_col    = in_rcol;
        rd_res.cell_row    = in_rrow;
        rd_res.cell_char   = SPACE_CODE;
        rd_res.cell_color  = BLACK;
        rd_res.glyph_drawn = 1'b0;
        rd_res.scrolled    = 1'b0;
        rd_res.cursor_col  = 7'(r_cx);
        rd_res.cursor_row  = 6'(r_cy);
    end

    always_comb begin
        n_state     = r_state;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_caddr     = r_caddr;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_snc       = r_snc;
        n_snr       = r_snr;
        n_wv        = 1'b0;
        n_wblank    = r_wblank;
        n_waddr     = r_waddr;
        n_res       = r_res;
        n_res_rd    = r_res_rd;
        n_res_blank = r_res_blank;
        s_axis_tready = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        we          = r_wv;
        wa          = r_waddr;
        wd          = r_wblank ? BLANK_CELL : r_q;
        out_load    = 1'b0;
        out_data    = r_res;
        if (r_res_rd) begin
            out_data.cell_char  = r_res_blank ? SPACE_CODE : r_q[31:24];
            out_data.cell_color = r_res_blank ? BLACK : r_q[23:0];
        end

        case (r_state)
            ST_CLEAR: begin
                we      = 1'b1;
                wa      = r_caddr;
                wd      = BLANK_CELL;
                n_caddr = r_caddr + AW'(1);
                if (r_caddr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = !r_wv;
                if (accept) begin
                    n_snc = nc;
                    n_snr = nr;
                    if (in_req) begin
                        rd_en       = 1'b1;
                        rd_addr     = {RW'(in_rrow), CW'(in_rcol)};
                        n_res       = rd_res;
                        n_res_rd    = 1'b1;
                        n_res_blank = !in_rng;
                        n_state     = ST_RESULT;
                    end else begin
                        n_cx        = nx;
                        n_cy        = ny;
                        n_res       = pr_res;
                        n_res_rd    = !is_glyph;
                        n_res_blank = 1'b0;
                        rd_en       = !is_glyph;
                        rd_addr     = {cy, cx};
                        if (is_glyph) begin
                            we = 1'b1;
                            wa = {cy, cx};
                            wd = {in_code, in_color};
                        end
                        if (is_glyph && !scroll && out_free) begin
                            out_load = 1'b1;
                            out_data = pr_res;
                        end else begin
                            n_state = ST_RESULT;
                        end
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_res.scrolled) begin
                        n_sx    = '0;
                        n_sy    = '0;
                        n_state = (r_snr == NRW'(1)) ? ST_BLANK : ST_COPY;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_COPY: begin
                rd_en    = 1'b1;
                rd_addr  = {r_sy + RW'(1), r_sx};
                n_wv     = 1'b1;
                n_wblank = 1'b0;
                n_waddr  = {r_sy, r_sx};
                if (NCW'(r_sx) + NCW'(1) == r_snc) begin
                    n_sx = '0;
                    n_sy = r_sy + RW'(1);
                    if (NRW'(r_sy) + NRW'(2) == r_snr) begin
                        n_state = ST_BLANK;
                    end
                end else begin
                    n_sx = r_sx + CW'(1);
                end
            end
            ST_BLANK: begin
                n_wv     = 1'b1;
                n_wblank = 1'b1;
                n_waddr  = {RW'(r_snr - NRW'(1)), r_sx};
                if (NCW'(r_sx) + NCW'(1) == r_snc) begin
                    n_state = ST_IDLE;
                end else begin
                    n_sx = r_sx + CW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_caddr  <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_wv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_caddr  <= n_caddr;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_wv     <= n_wv;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx        <= n_sx;
        r_sy        <= n_sy;
        r_snc       <= n_snc;
        r_snr       <= n_snr;
        r_wblank    <= n_wblank;
        r_waddr     <= n_waddr;
        r_res       <= n_res;
        r_res_rd    <= n_res_rd;
        r_res_blank <= n_res_blank;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_cells[wa] <= wd;
        end
        if (rd_en) begin
            r_q <= r_cells[rd_addr];
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {OUT_PAD_W'(0), r_out.cursor_row, r_out.cursor_col,
                            r_out.cell_color, r_out.cell_char,
                            r_out.cell_row, r_out.cell_col};
    assign m_axis_tuser  = {r_out.scrolled, r_out.glyph_drawn};

endmodule

`default_nettype wire

// ----- design/tcce_checker.sv -----
// ---------------------------------------------------------------------------
// Text console cell engine checker
// Port-level properties of the result stream and input ready, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none
`include "text_console_cell_engine_macros.svh"

module tcce_checker
    import tcce_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_s_tready,
    input wire logic                    i_m_tvalid,
    input wire logic                    i_m_tready,
    input wire logic [OUT_TDATA_W-1:0]  i_m_tdata,
    input wire logic [OUT_TUSER_W-1:0]  i_m_tuser
);

    `TCCE_ASSERT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "stalled result transaction changed")
    `TCCE_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_m_tvalid && !i_s_tready, "stream active straight after reset")
    `TCCE_ASSERT(a_glyph_char, i_clk, i_rst_n, i_m_tvalid && i_m_tuser[OUT_GLYPH_BIT] |-> (i_m_tdata[OUT_CHAR_LSB +: 8] != NUL_CODE) && (i_m_tdata[OUT_CHAR_LSB +: 8] != NL_CODE) && (i_m_tdata[OUT_CHAR_LSB +: 8] != SPACE_CODE), "glyph flagged for a control byte")
    `TCCE_ASSERT(a_scroll_col, i_clk, i_rst_n, i_m_tvalid && i_m_tuser[OUT_SCROLL_BIT] |-> (i_m_tdata[OUT_CCOL_LSB +: 7] == 7'd0) && !(i_m_tuser[OUT_GLYPH_BIT] && (i_m_tdata[OUT_CHAR_LSB +: 8] == NL_CODE)), "scroll left cursor off column zero")

endmodule

bind text_console_cell_engine tcce_checker u_tcce_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- dv/text_console_cell_engine_tb.sv -----
// ---------------------------------------------------------------------------
// Text console cell engine testbench
// Drives print and read transactions over the input stream, mirrors the cell
// grid, cursor and scroll behaviour in a local model and checks every result
// field against it. Covers reset geometry, a single-cell screen, the full
// 128x64 screen with wrap and scroll, cursor clamping after a geometry change
// and randomised traffic over narrow and wide screens with bursty input and
// stalling output.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_cell_engine_tb;
    import tcce_pkg::*;

    localparam int SCREEN_COLS   = 128;
    localparam int SCREEN_ROWS   = 64;
    localparam int SETTLE_CYCLES = SCREEN_COLS * SCREEN_ROWS + 64;
    localparam int CYCLE_LIMIT   = 3_000_000;

    localparam logic REQ_PRINT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_BURSTY
    } t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // char_code, char_color, read_col, read_row, zero pad
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    // req_type
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // cell_col, cell_row, cell_char, cell_color, cursor_col, cursor_row, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // glyph_drawn, scrolled
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    text_console_cell_engine #(
        .MAX_COLS (SCREEN_COLS),
        .MAX_ROWS (SCREEN_ROWS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic [31:0] screen [SCREEN_ROWS*SCREEN_COLS];
    int unsigned cur_x;
    int unsigned cur_y;
    logic [7:0]  cfg_cols;
    logic [6:0]  cfg_rows;

    t_result     cell_results_due [$];
    t_result     got_cell;
    t_result     want_cell;

    int          error_count;
    int          items_sent;
    int          reads_sent;
    int          results_checked;
    int          glyphs_seen;
    int          scrolls_seen;
    int          burst_left;
    bit          gapless;
    int unsigned cycle_count;

    t_rx_mode    rx_mode;
    logic [7:0]  rx_tick;
    int          rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned active_cols();
        if (cfg_cols == 8'd0)
            return 1;
        if (cfg_cols > SCREEN_COLS)
            return SCREEN_COLS;
        return cfg_cols;
    endfunction

    function automatic int unsigned active_rows();
        if (cfg_rows == 7'd0)
            return 1;
        if (cfg_rows > SCREEN_ROWS)
            return SCREEN_ROWS;
        return cfg_rows;
    endfunction

    function automatic t_result advance_console(input logic req, input logic [7:0] code,
                                                input logic [23:0] color,
                                                input logic [6:0] rcol, input logic [5:0] rrow);
        t_result     r;
        int unsigned nc;
        int unsigned nr;
        int unsigned xx;
        int unsigned yy;
        logic [31:0] cell_word;
        bit          wrap;
        nc   = active_cols();
        nr   = active_rows();
        r    = '0;
        wrap = 1'b0;
        if (req == REQ_READ) begin
            r.cell_col = rcol;
            r.cell_row = rrow;
            cell_word = (rcol < nc && rrow < nr) ? screen[rrow*SCREEN_COLS + rcol] : BLANK_CELL;
        end else begin
            if (cur_x >= nc)
                cur_x = nc - 1;
            if (cur_y >= nr)
                cur_y = nr - 1;
            r.cell_col = cur_x[6:0];
            r.cell_row = cur_y[5:0];
            if (code != NUL_CODE && code != NL_CODE && code != SPACE_CODE) begin
                screen[cur_y*SCREEN_COLS + cur_x] = {code, color};
                r.glyph_drawn = 1'b1;
            end
            cell_word = screen[cur_y*SCREEN_COLS + cur_x];
            if (code == NL_CODE) begin
                wrap = 1'b1;
            end else if (code != NUL_CODE) begin
                cur_x++;
                if (cur_x >= nc)
                    wrap = 1'b1;
            end
            if (wrap) begin
                cur_x = 0;
                cur_y++;
                if (cur_y >= nr) begin
                    for (yy = 0; yy + 1 < nr; yy++)
                        for (xx = 0; xx < nc; xx++)
                            screen[yy*SCREEN_COLS + xx] = screen[(yy+1)*SCREEN_COLS + xx];
                    for (xx = 0; xx < nc; xx++)
                        screen[(nr-1)*SCREEN_COLS + xx] = BLANK_CELL;
                    cur_y = nr - 1;
                    r.scrolled = 1'b1;
                end
            end
        end
        r.cell_char  = cell_word[31:24];
        r.cell_color = cell_word[23:0];
        r.cursor_col = cur_x[6:0];
        r.cursor_row = cur_y[5:0];
        return r;
    endfunction

    function automatic logic [7:0] printable();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == NL_CODE || c == SPACE_CODE);
        return c;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    task automatic send_item(input logic req, input logic [7:0] code, input logic [23:0] color,
                             input logic [6:0] rcol, input logic [5:0] rrow);
        logic [IN_TDATA_W-1:0] word;
        int                    gap;
        word = '0;
        word[IN_CODE_LSB  +: 8]  = code;
        word[IN_COLOR_LSB +: 24] = color;
        word[IN_RCOL_LSB  +: 7]  = rcol;
        word[IN_RROW_LSB  +: 6]  = rrow;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= req;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        cell_results_due.push_back(advance_console(req, code, color, rcol, rrow));
        items_sent++;
        if (req == REQ_READ)
            reads_sent++;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (!gapless) begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic print_char(input logic [7:0] code);
        send_item(REQ_PRINT, code, 24'($urandom), 7'($urandom), 6'($urandom));
    endtask

    task automatic read_cell(input logic [6:0] col, input logic [5:0] row);
        send_item(REQ_READ, 8'($urandom), 24'($urandom), col, row);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (cell_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // hold off until results are in and any trailing scroll has finished
    task automatic quiesce();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_screen(input logic [7:0] cols, input logic [7:0] rows_raw);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_COLUMNS;
        i_cfg_data  <= cols;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_cols = cols;
        i_cfg_index <= REG_ROWS;
        i_cfg_data  <= rows_raw;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_rows = rows_raw[6:0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 14)
            read_cell(7'($urandom_range(0, active_cols() - 1)),
                      6'($urandom_range(0, active_rows() - 1)));
        else if (pick < 19)
            read_cell(7'($urandom), 6'($urandom));
        else if (pick < 31)
            print_char(NL_CODE);
        else if (pick < 39)
            print_char(SPACE_CODE);
        else if (pick < 43)
            print_char(NUL_CODE);
        else
            print_char(printable());
    endtask

    task automatic test_reset_geometry();
        send_item(REQ_PRINT, 8'h41, 24'hffffff, 7'h7f, 6'h3f);
        send_item(REQ_PRINT, 8'hff, BLACK, 7'h00, 6'h00);
        send_item(REQ_PRINT, 8'h01, 24'ha5a5a5, 7'h2a, 6'h15);
        print_char(SPACE_CODE);
        print_char(NUL_CODE);
        print_char(8'h5a);
        print_char(NL_CODE);
        read_cell(7'd0, 6'd0);
        read_cell(7'd1, 6'd0);
        read_cell(7'd3, 6'd0);
        read_cell(7'd79, 6'd24);
        read_cell(7'd80, 6'd0);
        read_cell(7'd0, 6'd25);
        read_cell(7'd127, 6'd63);
    endtask

    task automatic test_single_cell();
        quiesce();
        set_screen(8'd0, 8'd0);
        print_char(8'h58);
        read_cell(7'd0, 6'd0);
        read_cell(7'd1, 6'd0);
        print_char(NL_CODE);
        print_char(SPACE_CODE);
        print_char(NUL_CODE);
    endtask

    task automatic test_full_screen();
        int k;
        quiesce();
        set_screen(8'hff, 8'hff);
        while (cur_y < active_rows() - 1)
            print_char(NL_CODE);
        for (k = 0; k < SCREEN_COLS; k++)
            print_char(printable());
        for (k = 0; k < 16; k++)
            read_cell(7'($urandom), 6'd62);
        read_cell(7'd127, 6'd63);
        read_cell(7'd0, 6'd0);
        for (k = 0; k < 40; k++)
            print_char(printable());
    endtask

    task automatic test_cursor_clamp();
        quiesce();
        set_screen(8'd5, 8'd3);
        print_char(printable());
        read_cell(7'd4, 6'd1);
        read_cell(7'd5, 6'd0);
        print_char(NL_CODE);
    endtask

    task automatic test_random_traffic();
        int phase;
        int k;
        int n;
        for (phase = 0; phase < 8; phase++) begin
            quiesce();
            if (phase % 2 == 0)
                set_screen(8'($urandom_range(0, 16)),
                           {1'($urandom), 7'($urandom_range(0, 10))});
            else
                set_screen(8'($urandom_range(17, 200)),
                           {1'($urandom), 7'($urandom_range(0, 4))});
            gapless = ($urandom_range(0, 3) == 0);
            n = $urandom_range(110, 150);
            for (k = 0; k < n; k++) begin
                if (k == n / 2 && phase % 3 == 0)
                    drain_results();
                random_item();
            end
        end
        gapless = 1'b0;
    endtask

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_tick == 8'd0)
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
        if (rx_hold != 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN: begin
                    m_axis_tready <= 1'b1;
                end
                RX_RANDOM: begin
                    m_axis_tready <= ($urandom_range(0, 2) != 0);
                end
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        rx_hold       <= $urandom_range(1, 12);
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_cell.cell_col    = m_axis_tdata[OUT_COL_LSB   +: 7];
            got_cell.cell_row    = m_axis_tdata[OUT_ROW_LSB   +: 6];
            got_cell.cell_char   = m_axis_tdata[OUT_CHAR_LSB  +: 8];
            got_cell.cell_color  = m_axis_tdata[OUT_COLOR_LSB +: 24];
            got_cell.cursor_col  = m_axis_tdata[OUT_CCOL_LSB  +: 7];
            got_cell.cursor_row  = m_axis_tdata[OUT_CROW_LSB  +: 6];
            got_cell.glyph_drawn = m_axis_tuser[OUT_GLYPH_BIT];
            got_cell.scrolled    = m_axis_tuser[OUT_SCROLL_BIT];
            if (cell_results_due.size() == 0) begin
                $error("result transaction arrived with no cell result pending");
                error_count++;
            end else begin
                want_cell = cell_results_due.pop_front();
                compare_field("cell_col",    want_cell.cell_col,    got_cell.cell_col);
                compare_field("cell_row",    want_cell.cell_row,    got_cell.cell_row);
                compare_field("cell_char",   want_cell.cell_char,   got_cell.cell_char);
                compare_field("cell_color",  want_cell.cell_color,  got_cell.cell_color);
                compare_field("glyph_drawn", want_cell.glyph_drawn, got_cell.glyph_drawn);
                compare_field("scrolled",    want_cell.scrolled,    got_cell.scrolled);
                compare_field("cursor_col",  want_cell.cursor_col,  got_cell.cursor_col);
                compare_field("cursor_row",  want_cell.cursor_row,  got_cell.cursor_row);
                results_checked++;
                if (got_cell.glyph_drawn === 1'b1)
                    glyphs_seen++;
                if (got_cell.scrolled === 1'b1)
                    scrolls_seen++;
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("cycle limit of %0d reached, %0d cell results outstanding",
                 CYCLE_LIMIT, cell_results_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int i;
        for (i = 0; i < SCREEN_ROWS * SCREEN_COLS; i++)
            screen[i] = BLANK_CELL;
        cur_x           = 0;
        cur_y           = 0;
        cfg_cols        = COLUMNS_RESET;
        cfg_rows        = ROWS_RESET;
        error_count     = 0;
        items_sent      = 0;
        reads_sent      = 0;
        results_checked = 0;
        glyphs_seen     = 0;
        scrolls_seen    = 0;
        burst_left      = 1;
        gapless         = 1'b0;
        rx_mode         = RX_OPEN;
        rx_tick         = 8'd1;
        rx_hold         = 0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_COLUMNS;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_PRINT;
        m_axis_tready <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_geometry();
        test_single_cell();
        test_full_screen();
        test_cursor_clamp();
        test_random_traffic();

        quiesce();
        $display("%0d input transactions (%0d cell reads), %0d results checked",
                 items_sent, reads_sent, results_checked);
        $display("%0d glyphs stored, %0d scrolls over screens from 1x1 up to 128x64",
                 glyphs_seen, scrolls_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
